### src/pap_pkg.sv
// shared types and constants for the popup anchor placement block
package pap_pkg;

	localparam int SHADOW_BITS = 10;
	localparam int GRAV_BITS   = 4;
	localparam int CFG_IDX_BITS = 3;

	// gravity codes
	localparam logic [GRAV_BITS-1:0] GRAV_NW     = 4'd0;
	localparam logic [GRAV_BITS-1:0] GRAV_N      = 4'd1;
	localparam logic [GRAV_BITS-1:0] GRAV_NE     = 4'd2;
	localparam logic [GRAV_BITS-1:0] GRAV_W      = 4'd3;
	localparam logic [GRAV_BITS-1:0] GRAV_CENTER = 4'd4;
	localparam logic [GRAV_BITS-1:0] GRAV_E      = 4'd5;
	localparam logic [GRAV_BITS-1:0] GRAV_SW     = 4'd6;
	localparam logic [GRAV_BITS-1:0] GRAV_S      = 4'd7;
	localparam logic [GRAV_BITS-1:0] GRAV_SE     = 4'd8;
	localparam logic [GRAV_BITS-1:0] GRAV_STATIC = 4'd9;

	// position factor along one axis: 0 near edge, 1 middle, 2 far edge
	localparam logic [1:0] FAC_ZERO = 2'd0;
	localparam logic [1:0] FAC_HALF = 2'd1;
	localparam logic [1:0] FAC_FULL = 2'd2;

	// hint mask bit positions
	localparam int HINT_FLIP_X   = 0;
	localparam int HINT_FLIP_Y   = 1;
	localparam int HINT_SLIDE_X  = 2;
	localparam int HINT_SLIDE_Y  = 3;
	localparam int HINT_RESIZE_X = 4;
	localparam int HINT_RESIZE_Y = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_BOUNDS_X      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOUNDS_Y      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOUNDS_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOUNDS_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHADOW_LEFT   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHADOW_RIGHT  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHADOW_TOP    = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHADOW_BOTTOM = 3'd7;

	typedef struct packed {
		logic flip;
		logic slide;
		logic resize;
	} pap_hint_t;

	// static counts as west on x
	function automatic logic [1:0] factor_x(input logic [GRAV_BITS-1:0] g);
		logic [1:0] f;
		case (g) inside
			GRAV_NW, GRAV_W, GRAV_SW, GRAV_STATIC: f = FAC_ZERO;
			GRAV_NE, GRAV_E, GRAV_SE:              f = FAC_FULL;
			default:                               f = FAC_HALF;
		endcase
		return f;
	endfunction

	// static counts as north on y
	function automatic logic [1:0] factor_y(input logic [GRAV_BITS-1:0] g);
		logic [1:0] f;
		case (g) inside
			GRAV_NW, GRAV_N, GRAV_NE, GRAV_STATIC: f = FAC_ZERO;
			GRAV_SW, GRAV_S, GRAV_SE:              f = FAC_FULL;
			default:                               f = FAC_HALF;
		endcase
		return f;
	endfunction

endpackage

### src/pap_cfg.sv
// configuration registers: work area bounds and shadow margins
module pap_cfg #(
	parameter int COORD_BITS = 16,
	parameter int DATA_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [pap_pkg::CFG_IDX_BITS-1:0]     wr_index,
	input  logic [DATA_BITS-1:0]                 wr_data,
	output logic signed [COORD_BITS-1:0]         bounds_x,
	output logic signed [COORD_BITS-1:0]         bounds_y,
	output logic [COORD_BITS-2:0]                bounds_width,
	output logic [COORD_BITS-2:0]                bounds_height,
	output logic [pap_pkg::SHADOW_BITS-1:0]      marg_left,
	output logic [pap_pkg::SHADOW_BITS-1:0]      marg_right,
	output logic [pap_pkg::SHADOW_BITS-1:0]      marg_top,
	output logic [pap_pkg::SHADOW_BITS-1:0]      marg_bottom
);
	import pap_pkg::*;

	logic signed [COORD_BITS-1:0] bx_q, by_q;
	logic [COORD_BITS-2:0]        bw_q, bh_q;
	logic [SHADOW_BITS-1:0]       sl_q, sr_q, st_q, sb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bx_q <= '0;
			by_q <= '0;
			bw_q <= '0;
			bh_q <= '0;
			sl_q <= '0;
			sr_q <= '0;
			st_q <= '0;
			sb_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_BOUNDS_X:      bx_q <= wr_data[COORD_BITS-1:0];
				REG_BOUNDS_Y:      by_q <= wr_data[COORD_BITS-1:0];
				REG_BOUNDS_WIDTH:  bw_q <= wr_data[COORD_BITS-2:0];
				REG_BOUNDS_HEIGHT: bh_q <= wr_data[COORD_BITS-2:0];
				REG_SHADOW_LEFT:   sl_q <= wr_data[SHADOW_BITS-1:0];
				REG_SHADOW_RIGHT:  sr_q <= wr_data[SHADOW_BITS-1:0];
				REG_SHADOW_TOP:    st_q <= wr_data[SHADOW_BITS-1:0];
				REG_SHADOW_BOTTOM: sb_q <= wr_data[SHADOW_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign bounds_x      = bx_q;
	assign bounds_y      = by_q;
	assign bounds_width  = bw_q;
	assign bounds_height = bh_q;
	assign marg_left     = sl_q;
	assign marg_right    = sr_q;
	assign marg_top      = st_q;
	assign marg_bottom   = sb_q;

endmodule

### src/pap_axis.sv
// six-stage placement pipeline for one axis: place, flip, slide, trim, restore shadows
module pap_axis #(
	parameter int COORD_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [COORD_BITS-1:0]       anc_pos,
	input  logic [COORD_BITS-2:0]              anc_size,
	input  logic [COORD_BITS-2:0]              win_size,
	input  logic [1:0]                         anchor_fac,
	input  logic [1:0]                         win_fac,
	input  logic signed [COORD_BITS-1:0]       offset,
	input  pap_pkg::pap_hint_t                 hint,
	input  logic signed [COORD_BITS-1:0]       bound_pos,
	input  logic [COORD_BITS-2:0]              bound_size,
	input  logic [pap_pkg::SHADOW_BITS-1:0]    shadow_lo,
	input  logic [pap_pkg::SHADOW_BITS-1:0]    shadow_hi,
	output logic                               out_valid,
	output logic signed [COORD_BITS+1:0]       flip_pos,
	output logic signed [COORD_BITS+1:0]       flip_size,
	output logic signed [COORD_BITS+1:0]       final_pos,
	output logic signed [COORD_BITS+1:0]       final_size,
	output logic                               flipped,
	output logic                               size_changed
);
	import pap_pkg::*;

	// internal width holds every exact intermediate value
	localparam int W  = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
	localparam int OW = COORD_BITS + 2;

	// (f * s) / 2 with truncation toward zero
	function automatic logic signed [W-1:0] scale_term(input logic [1:0] f,
	                                                   input logic signed [W-1:0] s);
		logic signed [W-1:0] adj;
		logic signed [W-1:0] res;
		adj = s + $signed({{(W-1){1'b0}}, s[W-1]});
		case (f)
			FAC_ZERO: res = '0;
			FAC_HALF: res = adj >>> 1;
			default:  res = s;
		endcase
		return res;
	endfunction

	logic signed [W-1:0] bp_w, be_q, sl_w, sh_w, rs_w;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [W-1:0] iw_s1, a1_s1, a2_s1;
	logic [1:0]          wf_s1;
	pap_hint_t           hint_s1;

	logic signed [W-1:0] iw_s2, p1_s2, p2_s2;
	pap_hint_t           hint_s2;

	logic signed [W-1:0] iw_s3, p_s3;
	logic                fl_s3;
	pap_hint_t           hint_s3;

	logic signed [W-1:0] iw_s4, p_s4, q_s4;
	logic                fl_s4;
	pap_hint_t           hint_s4;

	logic signed [W-1:0] iw_s5, p_s5, q_s5, sz_s5;
	logic                fl_s5;
	pap_hint_t           hint_s5;

	logic signed [OW-1:0] fpos_s6, fsize_s6, qpos_s6, qsize_s6;
	logic                 fl_s6, diff_s6;

	logic                fit1, fit2, use_second;
	logic signed [W-1:0] slid;
	logic signed [W-1:0] tq, tsz;

	assign bp_w = W'(bound_pos);
	assign sl_w = $signed(W'(shadow_lo));
	assign sh_w = $signed(W'(shadow_hi));
	assign rs_w = $signed(W'(anc_size));

	always_ff @(posedge clk) begin
		be_q <= bp_w + $signed(W'(bound_size));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage 1: inner size and anchor points of both placements
	always_ff @(posedge clk) begin
		iw_s1   <= $signed(W'(win_size)) - sl_w - sh_w;
		a1_s1   <= W'(anc_pos) + scale_term(anchor_fac, rs_w) + W'(offset);
		a2_s1   <= W'(anc_pos) + scale_term(FAC_FULL - anchor_fac, rs_w) - W'(offset);
		wf_s1   <= win_fac;
		hint_s1 <= hint;
	end

	// stage 2: subtract window point
	always_ff @(posedge clk) begin
		p1_s2   <= a1_s1 - scale_term(wf_s1, iw_s1);
		p2_s2   <= a2_s1 - scale_term(FAC_FULL - wf_s1, iw_s1);
		iw_s2   <= iw_s1;
		hint_s2 <= hint_s1;
	end

	// stage 3: with the flip hint, keep mirrored placement only if first leaves bounds and mirror fits
	always_comb begin
		fit1 = (p1_s2 >= bp_w) && (p1_s2 + iw_s2 <= be_q);
		fit2 = (p2_s2 >= bp_w) && (p2_s2 + iw_s2 <= be_q);
		use_second = hint_s2.flip && !fit1 && fit2;
	end

	always_ff @(posedge clk) begin
		p_s3    <= use_second ? p2_s2 : p1_s2;
		fl_s3   <= use_second;
		iw_s3   <= iw_s2;
		hint_s3 <= hint_s2;
	end

	// stage 4: with the slide hint, slide into bounds, far edge first then near edge
	always_comb begin
		slid = p_s3;
		if (p_s3 + iw_s3 > be_q) begin
			slid = be_q - iw_s3;
		end
		if (slid < bp_w) begin
			slid = bp_w;
		end
	end

	always_ff @(posedge clk) begin
		q_s4    <= hint_s3.slide ? slid : p_s3;
		p_s4    <= p_s3;
		fl_s4   <= fl_s3;
		iw_s4   <= iw_s3;
		hint_s4 <= hint_s3;
	end

	// stage 5: with the resize hint, trim size to bounds
	always_comb begin
		tq  = q_s4;
		tsz = iw_s4;
		if (tq < bp_w) begin
			tsz = tsz - (bp_w - tq);
			tq  = bp_w;
		end
		if (tq + tsz > be_q) begin
			tsz = be_q - tq;
		end
	end

	always_ff @(posedge clk) begin
		q_s5    <= hint_s4.resize ? tq : q_s4;
		sz_s5   <= hint_s4.resize ? tsz : iw_s4;
		p_s5    <= p_s4;
		fl_s5   <= fl_s4;
		iw_s5   <= iw_s4;
		hint_s5 <= hint_s4;
	end

	// stage 6: shadows back in, reduce to output width
	always_ff @(posedge clk) begin
		fpos_s6  <= OW'(p_s5 - sl_w);
		fsize_s6 <= OW'(iw_s5 + sl_w + sh_w);
		qpos_s6  <= OW'(q_s5 - sl_w);
		qsize_s6 <= OW'(sz_s5 + sl_w + sh_w);
		fl_s6    <= fl_s5;
		diff_s6  <= (sz_s5 != iw_s5);
	end

	assign out_valid    = v_s6;
	assign flip_pos     = fpos_s6;
	assign flip_size    = fsize_s6;
	assign final_pos    = qpos_s6;
	assign final_size   = qsize_s6;
	assign flipped      = fl_s6;
	assign size_changed = diff_s6;

`ifndef NO_ASSERTIONS
	a_slide_inside: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && hint_s4.slide |-> q_s4 >= bp_w)
		else $error("slid position left of bounds");

	a_no_resize_same_size: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !hint_s5.resize |=> !diff_s6)
		else $error("size changed without resize hint");

	a_flip_needs_hint: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && fl_s4 |-> $past(hint_s2.flip, 2))
		else $error("flip taken without flip hint");
`endif

endmodule

### src/popup_anchor_placement.sv
// top level of the popup anchor placement block
//
// places a popup window next to an anchor rectangle inside a work area
// request channel: start with the anchor, window and hint fields; a request
// is taken at every clock edge where start is high and busy is low
// busy is always low: the block takes a new request in every cycle
// result channel: done is high for one cycle with all result fields valid;
// the receiver has no way to hold results off and none are needed
// a request passes through all stages of both axis pipelines before its result
// shows; throughput one request per cycle
// the x and y axes each run a six-stage pipeline (placement points, window
// point, flip choice, slide, trim, shadow restore)
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while no request is in flight
// reset: clears bounds and shadows to zero and empties the pipeline
module popup_anchor_placement #(
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// request channel
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_BITS-1:0]        anchor_x,
	input  logic signed [COORD_BITS-1:0]        anchor_y,
	input  logic [COORD_BITS-2:0]               anchor_width,
	input  logic [COORD_BITS-2:0]               anchor_height,
	input  logic [COORD_BITS-2:0]               window_width,
	input  logic [COORD_BITS-2:0]               window_height,
	input  logic [pap_pkg::GRAV_BITS-1:0]       anchor_gravity,
	input  logic [pap_pkg::GRAV_BITS-1:0]       window_gravity,
	input  logic [5:0]                          hint_mask,
	input  logic signed [COORD_BITS-1:0]        offset_x,
	input  logic signed [COORD_BITS-1:0]        offset_y,

	// result channel
	output logic                                done,
	output logic signed [COORD_BITS+1:0]        flipped_left,
	output logic signed [COORD_BITS+1:0]        flipped_top,
	output logic signed [COORD_BITS+1:0]        flipped_w,
	output logic signed [COORD_BITS+1:0]        flipped_h,
	output logic signed [COORD_BITS+1:0]        final_left,
	output logic signed [COORD_BITS+1:0]        final_top,
	output logic signed [COORD_BITS+1:0]        final_w,
	output logic signed [COORD_BITS+1:0]        final_h,
	output logic                                flipped_horizontal,
	output logic                                flipped_vertical,
	output logic                                resize_needed,

	// configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pap_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [((COORD_BITS > pap_pkg::SHADOW_BITS) ?
	               COORD_BITS : pap_pkg::SHADOW_BITS)-1:0] cfg_data
);
	import pap_pkg::*;

	// config data is wide enough for the coordinates and the shadow margins
	localparam int DATA_BITS = (COORD_BITS > SHADOW_BITS) ? COORD_BITS : SHADOW_BITS;

	logic signed [COORD_BITS-1:0] bounds_x, bounds_y;
	logic [COORD_BITS-2:0]        bounds_width, bounds_height;
	logic [SHADOW_BITS-1:0]       marg_left, marg_right, marg_top, marg_bottom;

	logic       req_take;
	pap_hint_t  hint_x, hint_y;
	logic       done_x, done_y;
	logic       diff_x, diff_y;

	// never stalls: every start is a taken request
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign req_take  = start & ~busy;

	pap_cfg #(
		.COORD_BITS (COORD_BITS),
		.DATA_BITS  (DATA_BITS)
	) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (cfg_valid & cfg_ready),
		.wr_index      (cfg_index),
		.wr_data       (cfg_data),
		.bounds_x      (bounds_x),
		.bounds_y      (bounds_y),
		.bounds_width  (bounds_width),
		.bounds_height (bounds_height),
		.marg_left     (marg_left),
		.marg_right    (marg_right),
		.marg_top      (marg_top),
		.marg_bottom   (marg_bottom)
	);

	// split the hint mask per axis
	always_comb begin
		hint_x.flip   = hint_mask[HINT_FLIP_X];
		hint_x.slide  = hint_mask[HINT_SLIDE_X];
		hint_x.resize = hint_mask[HINT_RESIZE_X];
		hint_y.flip   = hint_mask[HINT_FLIP_Y];
		hint_y.slide  = hint_mask[HINT_SLIDE_Y];
		hint_y.resize = hint_mask[HINT_RESIZE_Y];
	end

	// horizontal axis: static gravity acts as west
	pap_axis #(
		.COORD_BITS (COORD_BITS)
	) u_axis_x (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req_take),
		.anc_pos      (anchor_x),
		.anc_size     (anchor_width),
		.win_size     (window_width),
		.anchor_fac   (factor_x(anchor_gravity)),
		.win_fac      (factor_x(window_gravity)),
		.offset       (offset_x),
		.hint         (hint_x),
		.bound_pos    (bounds_x),
		.bound_size   (bounds_width),
		.shadow_lo    (marg_left),
		.shadow_hi    (marg_right),
		.out_valid    (done_x),
		.flip_pos     (flipped_left),
		.flip_size    (flipped_w),
		.final_pos    (final_left),
		.final_size   (final_w),
		.flipped      (flipped_horizontal),
		.size_changed (diff_x)
	);

	// vertical axis: static gravity acts as north
	pap_axis #(
		.COORD_BITS (COORD_BITS)
	) u_axis_y (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req_take),
		.anc_pos      (anchor_y),
		.anc_size     (anchor_height),
		.win_size     (window_height),
		.anchor_fac   (factor_y(anchor_gravity)),
		.win_fac      (factor_y(window_gravity)),
		.offset       (offset_y),
		.hint         (hint_y),
		.bound_pos    (bounds_y),
		.bound_size   (bounds_height),
		.shadow_lo    (marg_top),
		.shadow_hi    (marg_bottom),
		.out_valid    (done_y),
		.flip_pos     (flipped_top),
		.flip_size    (flipped_h),
		.final_pos    (final_top),
		.final_size   (final_h),
		.flipped      (flipped_vertical),
		.size_changed (diff_y)
	);

	// both axes run in lockstep
	assign done          = done_x & done_y;
	assign resize_needed = diff_x | diff_y;

`ifndef NO_ASSERTIONS
	a_axes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_x == done_y)
		else $error("axis pipelines out of step");

	a_done_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(req_take, 6))
		else $error("result without matching request");

	a_request_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |-> ##6 done)
		else $error("request lost in pipeline");
`endif

endmodule
